// ===== sv/iira_pkg.sv =====
// ----------------------------------------------------------------------------
// iira_pkg
// Shared types and constants for the indexed insert/remove array: operation
// codes, status codes, fixed port widths and the per-cell control word.
// ----------------------------------------------------------------------------
package iira_pkg;

  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 4;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_POP    = 3'd3,
    MODE_READ   = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // broadcast to every cell in the row
  typedef struct packed {
    logic shift_up;    // open a slot at the position, load the new word there
    logic shift_down;  // close the slot at the position
  } cell_ctrl_t;

endpackage

// ===== sv/iira_cell.sv =====
// ----------------------------------------------------------------------------
// iira_cell
// One storage slot of the row. Holds a word and, per cycle, keeps it, takes
// the lower neighbor, takes the upper neighbor or loads the new word.
// ----------------------------------------------------------------------------
module iira_cell #(
  parameter int DW  = 32,
  parameter int IW  = 4,
  parameter int POS = 0
) (
  input  logic                clk_i,
  input  iira_pkg::cell_ctrl_t ctrl_i,
  input  logic [IW-1:0]       pos_i,
  input  logic [DW-1:0]       wdata_i,
  input  logic [DW-1:0]       lower_i,
  input  logic [DW-1:0]       upper_i,
  output logic [DW-1:0]       data_o
);

  localparam logic [IW-1:0] MY_POS = IW'(POS);

  logic [DW-1:0] data_q;
  logic [DW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      if (MY_POS > pos_i) begin
        data_d = lower_i;
      end else if (MY_POS == pos_i) begin
        data_d = wdata_i;
      end
    end else if (ctrl_i.shift_down) begin
      // cells past the count pick up don't-care words
      if (MY_POS >= pos_i) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== sv/indexed_insert_remove_array_core.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_core
// Ordered store of up to DEPTH words with append, insert, remove, pop, read
// and clear, built as a row of cells that all shift in the same cycle.
// ----------------------------------------------------------------------------
// the result strobe comes in the cycle after start; all shifting is done on that same edge
// throughput: one word per cycle, busy never rises
// the row of cells shifts in parallel; one read mux picks the returned word
// reset clears the count and the strobe; cell contents are left as they are
// the receiver cannot stall: each result shows for exactly one cycle
module indexed_insert_remove_array_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [iira_pkg::MODE_W-1:0]   mode_i,
  input  logic [iira_pkg::INDEX_W-1:0]  index_i,
  input  logic [iira_pkg::WORD_W-1:0]   write_data_i,
  output logic                          done_o,
  output logic [iira_pkg::STATUS_W-1:0] status_o,
  output logic [iira_pkg::WORD_W-1:0]   read_data_o,
  output logic [iira_pkg::COUNT_W-1:0]  item_count_o
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > iira_pkg::INDEX_W) ? CW : iira_pkg::INDEX_W;
  localparam int DW   = DATA_WIDTH;

  logic [CW-1:0]   count_q;
  logic [CW-1:0]   count_d;
  logic            done_q;
  logic [iira_pkg::STATUS_W-1:0] status_q;
  logic [iira_pkg::WORD_W-1:0]   rdata_q;
  logic [iira_pkg::COUNT_W-1:0]  cnt_out_q;

  logic [DW-1:0]   cell_data [DEPTH];
  logic [DW-1:0]   wdata;
  logic [CMPW-1:0] idx_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            full;
  logic            empty;
  logic            accept;

  iira_pkg::cell_ctrl_t ctrl;
  iira_pkg::status_e    status;
  logic [IW-1:0]        pos;
  logic [IW-1:0]        rd_addr;
  logic                 rd_en;
  logic [DW-1:0]        rd_word;

  assign accept  = start & ~busy;
  assign busy    = 1'b0;
  assign wdata   = DW'(write_data_i);
  assign idx_ext = CMPW'(index_i);
  assign cnt_ext = CMPW'(count_q);
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);

  // operation decode
  always_comb begin
    ctrl    = '0;
    status  = iira_pkg::STATUS_OK;
    pos     = '0;
    rd_addr = '0;
    rd_en   = 1'b0;
    count_d = count_q;
    unique case (iira_pkg::mode_e'(mode_i))
      iira_pkg::MODE_APPEND: begin
        if (full) begin
          status = iira_pkg::STATUS_FULL;
        end else begin
          ctrl.shift_up = accept;
          pos           = IW'(count_q);
          count_d       = count_q + CW'(1);
        end
      end
      iira_pkg::MODE_INSERT: begin
        if (idx_ext > cnt_ext) begin
          status = iira_pkg::STATUS_BAD_INDEX;
        end else if (full) begin
          status = iira_pkg::STATUS_FULL;
        end else begin
          ctrl.shift_up = accept;
          pos           = IW'(idx_ext);
          count_d       = count_q + CW'(1);
        end
      end
      iira_pkg::MODE_REMOVE: begin
        if (idx_ext >= cnt_ext) begin
          status = iira_pkg::STATUS_BAD_INDEX;
        end else begin
          ctrl.shift_down = accept;
          pos             = IW'(idx_ext);
          count_d         = count_q - CW'(1);
        end
      end
      iira_pkg::MODE_POP: begin
        if (empty) begin
          status = iira_pkg::STATUS_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(count_q - CW'(1));
          count_d = count_q - CW'(1);
        end
      end
      iira_pkg::MODE_READ: begin
        if (idx_ext >= cnt_ext) begin
          status = iira_pkg::STATUS_BAD_INDEX;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_ext);
        end
      end
      iira_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // single read port over the row, taken before the row updates
  assign rd_word = rd_en ? cell_data[rd_addr] : '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DW-1:0] lower;
    logic [DW-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = wdata;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    iira_cell #(
      .DW  (DW),
      .IW  (IW),
      .POS (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos),
      .wdata_i (wdata),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status;
      rdata_q   <= iira_pkg::WORD_W'(rd_word);
      cnt_out_q <= iira_pkg::COUNT_W'(count_d);
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_data_o  = rdata_q;
  assign item_count_o = cnt_out_q;

endmodule

// ===== tb/sv/tb_indexed_insert_remove_array_core.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_array_core
// Self-checking bench for the indexed insert/remove array. A local copy of the
// store predicts status, returned word and count for every accepted command.
// Each strobed result is checked against the oldest prediction. Directed
// cases cover empty, full and out-of-range handling. A long random mix of
// fill and drain phases follows, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_array_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int RANDOM_OPS = 1250;

  // codes with no operation behind them
  localparam logic [iira_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [iira_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [iira_pkg::STATUS_W-1:0] status;
    logic [iira_pkg::WORD_W-1:0]   read_data;
    logic [iira_pkg::COUNT_W-1:0]  item_count;
  } array_result_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          start        = 1'b0;
  logic                          busy;
  logic [iira_pkg::MODE_W-1:0]   mode_i       = '0;
  logic [iira_pkg::INDEX_W-1:0]  index_i      = '0;
  logic [iira_pkg::WORD_W-1:0]   write_data_i = '0;
  logic                          done_o;
  logic [iira_pkg::STATUS_W-1:0] status_o;
  logic [iira_pkg::WORD_W-1:0]   read_data_o;
  logic [iira_pkg::COUNT_W-1:0]  item_count_o;

  // shadow copy of the store
  logic [DATA_WIDTH-1:0] shadow_cells [DEPTH];
  int                    shadow_count = 0;

  array_result_t pending_results [$];
  int            mismatch_count = 0;
  int            burst_left     = 0;

  indexed_insert_remove_array_core #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .index_i     (index_i),
    .write_data_i(write_data_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_data_o (read_data_o),
    .item_count_o(item_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // apply one command to the shadow store and return what the block should say
  function automatic array_result_t apply_array_op(
      input logic [iira_pkg::MODE_W-1:0] m,
      input logic [iira_pkg::INDEX_W-1:0] ix,
      input logic [iira_pkg::WORD_W-1:0] wd);
    array_result_t r;
    int            pos;
    int            k;
    pos         = int'(ix);
    r.status    = iira_pkg::STATUS_OK;
    r.read_data = '0;
    case (m)
      iira_pkg::MODE_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = iira_pkg::STATUS_FULL;
        end else begin
          shadow_cells[shadow_count] = wd[DATA_WIDTH-1:0];
          shadow_count++;
        end
      end
      iira_pkg::MODE_INSERT: begin
        // bad index wins over full
        if (pos > shadow_count) begin
          r.status = iira_pkg::STATUS_BAD_INDEX;
        end else if (shadow_count >= DEPTH) begin
          r.status = iira_pkg::STATUS_FULL;
        end else begin
          for (k = shadow_count; k > pos; k--) shadow_cells[k] = shadow_cells[k-1];
          shadow_cells[pos] = wd[DATA_WIDTH-1:0];
          shadow_count++;
        end
      end
      iira_pkg::MODE_REMOVE: begin
        if (pos >= shadow_count) begin
          r.status = iira_pkg::STATUS_BAD_INDEX;
        end else begin
          for (k = pos; k + 1 < shadow_count; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_count--;
        end
      end
      iira_pkg::MODE_POP: begin
        if (shadow_count == 0) begin
          r.status = iira_pkg::STATUS_EMPTY;
        end else begin
          shadow_count--;
          r.read_data = iira_pkg::WORD_W'(shadow_cells[shadow_count]);
        end
      end
      iira_pkg::MODE_READ: begin
        if (pos >= shadow_count) r.status = iira_pkg::STATUS_BAD_INDEX;
        else r.read_data = iira_pkg::WORD_W'(shadow_cells[pos]);
      end
      iira_pkg::MODE_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.item_count = iira_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_word(input logic [iira_pkg::MODE_W-1:0] m,
                           input logic [iira_pkg::INDEX_W-1:0] ix,
                           input logic [iira_pkg::WORD_W-1:0] wd);
    start        <= 1'b1;
    mode_i       <= m;
    index_i      <= ix;
    write_data_i <= wd;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_array_op(m, ix, wd));
    pace_sender();
  endtask

  always @(posedge clk_i) begin : check_result
    array_result_t want;
    if (done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, status %0d data %h count %0d", $time,
                 status_o, read_data_o, item_count_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (read_data_o !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                   read_data_o);
          mismatch_count++;
        end
        if (item_count_o !== want.item_count) begin
          $display("%0t: item_count expected %0d actual %0d", $time, want.item_count,
                   item_count_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_store();
    send_word(iira_pkg::MODE_POP, 4'd0, 32'h0);
    send_word(iira_pkg::MODE_READ, 4'd0, 32'h0);
    send_word(iira_pkg::MODE_REMOVE, 4'd0, 32'h0);
    send_word(iira_pkg::MODE_INSERT, 4'd1, 32'hDEAD_BEEF);  // past the end
    send_word(MODE_SPARE_LO, 4'd15, 32'hFFFF_FFFF);
    send_word(MODE_SPARE_HI, 4'd0, 32'h0);
  endtask

  task automatic test_fill_to_full();
    send_word(iira_pkg::MODE_INSERT, 4'd0, 32'hFFFF_FFFF);
    send_word(iira_pkg::MODE_APPEND, 4'd0, 32'h0000_0000);
    send_word(iira_pkg::MODE_INSERT, 4'd1, 32'hA5A5_A5A5);
    repeat (DEPTH - 3) send_word(iira_pkg::MODE_APPEND, 4'($urandom), $urandom);
    send_word(iira_pkg::MODE_APPEND, 4'd0, 32'h1234_5678);  // full
    send_word(iira_pkg::MODE_INSERT, 4'd15, 32'h8765_4321); // full with a valid index
    send_word(iira_pkg::MODE_READ, 4'd15, 32'h0);
  endtask

  task automatic test_drain();
    send_word(iira_pkg::MODE_REMOVE, 4'd0, 32'h0);
    send_word(iira_pkg::MODE_READ, 4'd15, 32'h0);           // now out of range
    send_word(iira_pkg::MODE_POP, 4'd0, 32'h0);
    send_word(iira_pkg::MODE_INSERT, 4'd14, 32'h5A5A_5A5A); // at the end
    send_word(iira_pkg::MODE_CLEAR, 4'd0, 32'h0);
    send_word(iira_pkg::MODE_POP, 4'd0, 32'h0);
  endtask

  // alternating fill and drain phases keep both full and empty in reach
  task automatic test_random_mix(input int n);
    logic [iira_pkg::MODE_W-1:0]  m;
    logic [iira_pkg::INDEX_W-1:0] ix;
    logic [iira_pkg::WORD_W-1:0]  wd;
    bit                           growing;
    int                           r;
    growing = 1'b1;
    repeat (n) begin
      if (shadow_count == DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
      if (shadow_count == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (growing) begin
        if (r < 35) m = iira_pkg::MODE_APPEND;
        else if (r < 65) m = iira_pkg::MODE_INSERT;
        else if (r < 75) m = iira_pkg::MODE_REMOVE;
        else if (r < 80) m = iira_pkg::MODE_POP;
        else if (r < 95) m = iira_pkg::MODE_READ;
        else if (r < 97) m = iira_pkg::MODE_CLEAR;
        else m = 3'($urandom_range(6, 7));
      end else begin
        if (r < 10) m = iira_pkg::MODE_APPEND;
        else if (r < 20) m = iira_pkg::MODE_INSERT;
        else if (r < 50) m = iira_pkg::MODE_REMOVE;
        else if (r < 75) m = iira_pkg::MODE_POP;
        else if (r < 95) m = iira_pkg::MODE_READ;
        else if (r < 97) m = iira_pkg::MODE_CLEAR;
        else m = 3'($urandom_range(6, 7));
      end
      if ($urandom_range(0, 9) < 8) begin
        if (m == iira_pkg::MODE_INSERT)
          ix = 4'($urandom_range(0, (shadow_count > 15) ? 15 : shadow_count));
        else
          ix = 4'($urandom_range(0, (shadow_count > 0) ? shadow_count - 1 : 0));
      end else begin
        ix = 4'($urandom_range(0, 15));
      end
      case ($urandom_range(0, 15))
        0:       wd = 32'h0000_0000;
        1:       wd = 32'hFFFF_FFFF;
        default: wd = $urandom;
      endcase
      send_word(m, ix, wd);
    end
  endtask

  initial begin
    int guard;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_store();
    test_fill_to_full();
    test_drain();
    test_random_mix(RANDOM_OPS);
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d words never returned", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
